// File: rtl/leonardo_heap_sorter_assert.svh
// Assertion macros used by the checker file.
`ifndef LEONARDO_HEAP_SORTER_ASSERT_SVH
`define LEONARDO_HEAP_SORTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LHS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/lhs_pkg.sv
// Types, constants and bitmap helpers for the Leonardo heap sorter.
package lhs_pkg;

    localparam int LEO_DEPTH = 20;
    localparam int ORD_W     = 5;
    localparam int LEO_W     = 16;
    localparam int POS_W     = 18;

    typedef logic [LEO_DEPTH-1:0] map_t;
    typedef logic [ORD_W-1:0]     ord_t;
    typedef logic [LEO_W-1:0]     leo_t;

    localparam leo_t LEO_SIZES [LEO_DEPTH] = '{
        16'd1, 16'd1, 16'd3, 16'd5, 16'd9, 16'd15, 16'd25, 16'd41, 16'd67, 16'd109,
        16'd177, 16'd287, 16'd465, 16'd753, 16'd1219, 16'd1973, 16'd3193, 16'd5167,
        16'd8361, 16'd13529
    };

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_GROW,
        ST_SCHK,
        ST_SRD0,
        ST_SRD1,
        ST_SRD2,
        ST_SCMP,
        ST_SSW,
        ST_SRET,
        ST_FINIT,
        ST_FV,
        ST_FNEXT,
        ST_FCMP,
        ST_XSW1,
        ST_XSW2,
        ST_SHRINK,
        ST_ORD,
        ST_OLD,
        ST_OWAIT
    } state_t;

    typedef struct packed {
        map_t map;
        logic merged;
        ord_t ord;
    } grow_t;

    typedef struct packed {
        logic found;
        ord_t idx;
    } bit_t;

    function automatic leo_t leo(input ord_t o);
        leo_t r;
        r = '0;
        if (int'(o) < LEO_DEPTH)
        begin
            r = LEO_SIZES[o];
        end
        return r;
    endfunction

    function automatic grow_t grow_map(input map_t m);
        grow_t g;
        logic  found;
        ord_t  idx;
        found = 1'b0;
        idx   = '0;
        g.map    = m;
        g.merged = 1'b0;
        g.ord    = '0;
        for (int k = 0; k < LEO_DEPTH - 1; k++)
        begin
            if (!found && m[k] && m[k+1])
            begin
                found = 1'b1;
                idx   = ORD_W'(k);
            end
        end
        if (m[2:0] == 3'b101)
        begin
            g.map    = m + map_t'(3);
            g.merged = 1'b1;
            g.ord    = ORD_W'(3);
        end
        else if (found)
        begin
            g.map    = m + (map_t'(1) << idx);
            g.merged = 1'b1;
            g.ord    = ORD_W'(idx + ORD_W'(2));
        end
        else if (m[0])
        begin
            g.map = m | map_t'(2);
        end
        else
        begin
            g.map = m | map_t'(1);
        end
        return g;
    endfunction

    function automatic bit_t next_set(input map_t m, input ord_t from, input logic incl);
        bit_t b;
        b.found = 1'b0;
        b.idx   = '0;
        for (int k = 0; k < LEO_DEPTH; k++)
        begin
            if (!b.found && m[k] && ((k > int'(from)) || (incl && k == int'(from))))
            begin
                b.found = 1'b1;
                b.idx   = ORD_W'(k);
            end
        end
        return b;
    endfunction

    function automatic map_t shrink_map(input map_t m);
        map_t r;
        bit_t b;
        r = m;
        b = next_set(m, '0, 1'b1);
        if (m[3:0] == 4'b1000)
        begin
            r = m - map_t'(3);
        end
        else if (m[0])
        begin
            r = m[1] ? (m ^ map_t'(2)) : (m ^ map_t'(1));
        end
        else if (b.found)
        begin
            r = m ^ (map_t'(1) << b.idx);
            r = r | (map_t'(1) << (b.idx - ORD_W'(1)));
            if (b.idx >= ORD_W'(2))
            begin
                r = r | (map_t'(1) << (b.idx - ORD_W'(2)));
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/lhs_in_if.sv
// Input channel: one element per beat.
interface lhs_in_if #(parameter int VALUE_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         is_final;

    modport source (output valid, output value, output is_final, input ready);
    modport sink (input valid, input value, input is_final, output ready);
endinterface

// File: rtl/lhs_out_if.sv
// Output channel: one sorted element per beat.
interface lhs_out_if #(parameter int VALUE_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] sorted_value;
    logic                         end_of_run;
    logic                         dropped;

    modport source (output valid, output sorted_value, output end_of_run, output dropped,
                    input ready);
    modport sink (input valid, input sorted_value, input end_of_run, input dropped,
                  output ready);
endinterface

// File: rtl/leonardo_heap_sorter.sv
// Top level: load, smoothsort in the element store, and emit in order.
//
//  channel | dir | payload                              | beat
//  din     | in  | value, is_final                      | one element
//  dout    | out | sorted_value, end_of_run, dropped    | one sorted element
//
// din is held off from the final beat until the last result is taken.
// Sorting runs on the store's one write and one read port: each sift level
// takes 3 reads and 2 writes, and each heap root scanned takes a read and a
// compare. Each result passes the states ORD, OLD and OWAIT.
// Reset is asynchronous and clears control state only; no clearing pass.
// A stall on dout holds the result register and the whole sequencer.
module leonardo_heap_sorter #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input logic clk,
    input logic rst_n,
    lhs_in_if.sink    din,
    lhs_out_if.source dout
);
    import lhs_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [VALUE_BITS-1:0] SIGN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    state_t state_reg, state_next;

    logic [CW-1:0]         cnt_reg, cnt_next;
    map_t                  map_reg, map_next;
    logic                  ovf_reg, ovf_next;
    logic                  ext_reg, ext_next;
    logic [CW-1:0]         i_reg, i_next;
    ord_t                  ord_reg, ord_next;
    ord_t                  nord_reg, nord_next;
    ord_t                  scan_reg, scan_next;
    logic [AW-1:0]         cur_reg, cur_next;
    logic [AW-1:0]         big_reg, big_next;
    logic [AW-1:0]         rgt_reg, rgt_next;
    logic [AW-1:0]         lft_reg, lft_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [POS_W-1:0]      root_reg, root_next;
    logic [VALUE_BITS-1:0] vcur_reg, vcur_next;
    logic [VALUE_BITS-1:0] vbig_reg, vbig_next;
    logic [VALUE_BITS-1:0] vi_reg, vi_next;
    logic                  ovalid_reg, ovalid_next;
    logic [VALUE_BITS-1:0] odata_reg, odata_next;
    logic                  oend_reg, oend_next;
    logic                  odrop_reg, odrop_next;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [VALUE_BITS-1:0] wdata, rdata;

    logic                  in_beat, room;
    logic [POS_W-1:0]      rgt_s, lft_s;
    grow_t                 grow_r;
    bit_t                  nbit, lbit;
    logic [AW-1:0]         fin_big;
    logic [VALUE_BITS-1:0] fin_vbig;
    ord_t                  fin_nord;

    lhs_store #(.DEPTH(MAX_ITEMS), .WIDTH(VALUE_BITS), .AW(AW)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign din.ready       = (state_reg == ST_LOAD);
    assign in_beat         = din.valid && din.ready;
    assign room            = (cnt_reg < CW'(MAX_ITEMS));
    assign dout.valid      = ovalid_reg;
    assign dout.sorted_value = odata_reg;
    assign dout.end_of_run = oend_reg;
    assign dout.dropped    = odrop_reg;

    assign rgt_s  = POS_W'(cur_reg) - POS_W'(1);
    assign lft_s  = rgt_s - POS_W'(leo(ORD_W'(ord_reg - ORD_W'(2))));
    assign grow_r = grow_map(map_reg);
    assign nbit   = next_set(map_reg, scan_reg, 1'b0);
    assign lbit   = next_set(map_reg, '0, 1'b1);

    always_comb
    begin
        fin_big  = big_reg;
        fin_vbig = vbig_reg;
        fin_nord = nord_reg;
        if (rdata > vbig_reg)
        begin
            fin_big  = lft_reg;
            fin_vbig = rdata;
            fin_nord = ORD_W'(ord_reg - ORD_W'(1));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:   if (in_beat && din.is_final) state_next = ST_GROW;
            ST_GROW:
            begin
                if (i_reg == cnt_reg)   state_next = ST_FINIT;
                else if (grow_r.merged) state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (ord_reg < ORD_W'(2) || rgt_s[POS_W-1] || lft_s[POS_W-1])
                    state_next = ST_SRET;
                else
                    state_next = ST_SRD0;
            end
            ST_SRD0:   state_next = ST_SRD1;
            ST_SRD1:   state_next = ST_SRD2;
            ST_SRD2:   state_next = ST_SCMP;
            ST_SCMP:   state_next = (fin_big == cur_reg) ? ST_SRET : ST_SSW;
            ST_SSW:    state_next = ST_SCHK;
            ST_SRET:   state_next = ext_reg ? ST_SHRINK : ST_GROW;
            ST_FINIT:  state_next = (map_reg == '0) ? ST_SHRINK : ST_FV;
            ST_FV:     state_next = ST_FNEXT;
            ST_FNEXT:
            begin
                if (!nbit.found || root_reg[POS_W-1])
                    state_next = (pos_reg != i_reg[AW-1:0]) ? ST_XSW1 : ST_SHRINK;
                else
                    state_next = ST_FCMP;
            end
            ST_FCMP:   state_next = ST_FNEXT;
            ST_XSW1:   state_next = ST_XSW2;
            ST_XSW2:   state_next = ST_SCHK;
            ST_SHRINK: state_next = (i_reg == '0) ? ST_ORD : ST_FINIT;
            ST_ORD:    state_next = ST_OLD;
            ST_OLD:    state_next = ST_OWAIT;
            ST_OWAIT:
            begin
                if (dout.ready) state_next = oend_reg ? ST_LOAD : ST_ORD;
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        map_next    = map_reg;
        ovf_next    = ovf_reg;
        ext_next    = ext_reg;
        i_next      = i_reg;
        ord_next    = ord_reg;
        nord_next   = nord_reg;
        scan_next   = scan_reg;
        cur_next    = cur_reg;
        big_next    = big_reg;
        rgt_next    = rgt_reg;
        lft_next    = lft_reg;
        pos_next    = pos_reg;
        root_next   = root_reg;
        vcur_next   = vcur_reg;
        vbig_next   = vbig_reg;
        vi_next     = vi_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        oend_next   = oend_reg;
        odrop_next  = odrop_reg;
        we          = 1'b0;
        waddr       = cur_reg;
        wdata       = vbig_reg;
        raddr       = cur_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                waddr = cnt_reg[AW-1:0];
                wdata = din.value ^ SIGN;
                if (in_beat)
                begin
                    if (room)
                    begin
                        we       = 1'b1;
                        cnt_next = CW'(cnt_reg + 1'b1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (din.is_final)
                    begin
                        i_next   = '0;
                        ext_next = 1'b0;
                        map_next = '0;
                    end
                end
            end
            ST_GROW:
            begin
                if (i_reg == cnt_reg)
                begin
                    ext_next = 1'b1;
                    i_next   = CW'(cnt_reg - 1'b1);
                end
                else
                begin
                    map_next = grow_r.map;
                    if (grow_r.merged)
                    begin
                        ord_next = grow_r.ord;
                        cur_next = i_reg[AW-1:0];
                    end
                    else
                    begin
                        i_next = CW'(i_reg + 1'b1);
                    end
                end
            end
            ST_SCHK:
            begin
                rgt_next = rgt_s[AW-1:0];
                lft_next = lft_s[AW-1:0];
            end
            ST_SRD0:
            begin
                raddr = cur_reg;
            end
            ST_SRD1:
            begin
                raddr     = rgt_reg;
                vcur_next = rdata;
            end
            ST_SRD2:
            begin
                raddr = lft_reg;
                if (rdata > vcur_reg)
                begin
                    big_next  = rgt_reg;
                    vbig_next = rdata;
                    nord_next = ORD_W'(ord_reg - ORD_W'(2));
                end
                else
                begin
                    big_next  = cur_reg;
                    vbig_next = vcur_reg;
                    nord_next = ord_reg;
                end
            end
            ST_SCMP:
            begin
                big_next  = fin_big;
                vbig_next = fin_vbig;
                nord_next = fin_nord;
                if (fin_big != cur_reg)
                begin
                    we    = 1'b1;
                    waddr = cur_reg;
                    wdata = fin_vbig;
                end
            end
            ST_SSW:
            begin
                we       = 1'b1;
                waddr    = big_reg;
                wdata    = vcur_reg;
                cur_next = big_reg;
                ord_next = nord_reg;
            end
            ST_SRET:
            begin
                if (!ext_reg)
                begin
                    i_next = CW'(i_reg + 1'b1);
                end
            end
            ST_FINIT:
            begin
                raddr     = i_reg[AW-1:0];
                scan_next = lbit.idx;
                ord_next  = lbit.idx;
                pos_next  = i_reg[AW-1:0];
                root_next = POS_W'(i_reg) - POS_W'(leo(lbit.idx));
            end
            ST_FV:
            begin
                vbig_next = rdata;
                vi_next   = rdata;
            end
            ST_FNEXT:
            begin
                raddr     = root_reg[AW-1:0];
                scan_next = nbit.idx;
            end
            ST_FCMP:
            begin
                if (rdata > vbig_reg)
                begin
                    pos_next  = root_reg[AW-1:0];
                    vbig_next = rdata;
                    ord_next  = scan_reg;
                end
                root_next = root_reg - POS_W'(leo(scan_reg));
            end
            ST_XSW1:
            begin
                we    = 1'b1;
                waddr = i_reg[AW-1:0];
                wdata = vbig_reg;
            end
            ST_XSW2:
            begin
                we       = 1'b1;
                waddr    = pos_reg;
                wdata    = vi_reg;
                cur_next = pos_reg;
            end
            ST_SHRINK:
            begin
                map_next = shrink_map(map_reg);
                if (i_reg != '0)
                begin
                    i_next = CW'(i_reg - 1'b1);
                end
            end
            ST_ORD:
            begin
                raddr = i_reg[AW-1:0];
            end
            ST_OLD:
            begin
                ovalid_next = 1'b1;
                odata_next  = rdata ^ SIGN;
                oend_next   = (i_reg == CW'(cnt_reg - 1'b1));
                odrop_next  = ovf_reg;
            end
            ST_OWAIT:
            begin
                if (dout.ready)
                begin
                    ovalid_next = 1'b0;
                    if (oend_reg)
                    begin
                        cnt_next = '0;
                        map_next = '0;
                        ovf_next = 1'b0;
                    end
                    else
                    begin
                        i_next = CW'(i_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            cnt_reg    <= '0;
            map_reg    <= '0;
            ovf_reg    <= 1'b0;
            ext_reg    <= 1'b0;
            i_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            map_reg    <= map_next;
            ovf_reg    <= ovf_next;
            ext_reg    <= ext_next;
            i_reg      <= i_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg   <= ord_next;
        nord_reg  <= nord_next;
        scan_reg  <= scan_next;
        cur_reg   <= cur_next;
        big_reg   <= big_next;
        rgt_reg   <= rgt_next;
        lft_reg   <= lft_next;
        pos_reg   <= pos_next;
        root_reg  <= root_next;
        vcur_reg  <= vcur_next;
        vbig_reg  <= vbig_next;
        vi_reg    <= vi_next;
        odata_reg <= odata_next;
        oend_reg  <= oend_next;
        odrop_reg <= odrop_next;
    end

endmodule

// File: rtl/lhs_store.sv
// Element store: one write port, one registered read port.
module lhs_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/lhs_checker.sv
// Port-level checks for the Leonardo heap sorter, bound to the top level.
module lhs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_final,
    input logic out_valid,
    input logic out_ready,
    input logic out_end
);

`include "leonardo_heap_sorter_assert.svh"

    `LHS_ASSERT_NOW(no_load_while_out, out_valid, !in_ready)
    `LHS_ASSERT_NEXT(final_closes_input, in_valid && in_ready && in_final, !in_ready)
    `LHS_ASSERT_NEXT(end_beat_clears, out_valid && out_ready && out_end, !out_valid)
    `LHS_ASSERT_NEXT(out_held, out_valid && !out_ready, out_valid && $stable(out_end))

endmodule

bind leonardo_heap_sorter lhs_checker u_lhs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .in_final  (din.is_final),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_end   (dout.end_of_run)
);
